@@ sv/rc4_pkg.sv @@
// Shared constants, types and key byte selection for the RC4 stream cipher.
package rc4_pkg;

	localparam int SBOX_DEPTH = 256;
	localparam int SBOX_AW    = $clog2(SBOX_DEPTH);
	localparam int BYTE_W     = 8;
	localparam int KEY_BYTES  = 16;
	localparam int KEY_IDX_W  = 4;
	localparam int CFG_AW     = 4;
	localparam int CFG_DW     = 64;

	localparam logic REG_KEY_LOW  = 1'b0;
	localparam logic REG_KEY_HIGH = 1'b1;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [SBOX_AW-1:0] sbox_addr_t;
	typedef logic [CFG_AW-1:0]  cfg_addr_t;
	typedef logic [CFG_DW-1:0]  cfg_data_t;
	typedef logic [KEY_IDX_W-1:0] key_idx_t;

	// Bytes 0..7 come from the low word, 8..15 from the high word.
	function automatic byte_t key_byte(input cfg_data_t lo, input cfg_data_t hi,
		input key_idx_t k);
		cfg_data_t word;
		word = k[3] ? hi : lo;
		return word[{k[2:0], 3'b000} +: BYTE_W];
	endfunction

endpackage

@@ sv/rc4_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ sv/rc4_stream_cipher.sv @@
// RC4 cipher: one data byte in, that byte XORed with the next keystream byte out.
// A new byte is accepted only in idle, once the previous result is in the output register.
// The pace is set by the S-box RAM, with one write and one read port: read S[i], read S[j],
// two swap writes, with the keystream read on the second write, then the output register load.
// The first byte of a message adds a restart: the fill of S, the key schedule and the
// issue of the first S[i] read.
// Reset clears keys and indices and arms the restart; the S-box RAM is not cleared.
module rc4_stream_cipher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  rc4_pkg::cfg_addr_t paddr,
	input  rc4_pkg::cfg_data_t pwdata,
	output rc4_pkg::cfg_data_t prdata,
	output logic              pready,
	input  logic              item_valid,
	output logic              item_ready,
	input  rc4_pkg::byte_t    data_byte,
	input  logic              last_byte,
	output logic              result_valid,
	input  logic              result_ready,
	output rc4_pkg::byte_t    out_byte,
	output logic              out_last
);

	import rc4_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FILL = 4'd1;
	localparam logic [3:0] ST_K_RI = 4'd2;
	localparam logic [3:0] ST_K_RJ = 4'd3;
	localparam logic [3:0] ST_K_WI = 4'd4;
	localparam logic [3:0] ST_K_WJ = 4'd5;
	localparam logic [3:0] ST_P_RI = 4'd6;
	localparam logic [3:0] ST_P_RJ = 4'd7;
	localparam logic [3:0] ST_P_WI = 4'd8;
	localparam logic [3:0] ST_P_WJ = 4'd9;
	localparam logic [3:0] ST_P_OUT = 4'd10;

	localparam sbox_addr_t LAST_ENTRY = sbox_addr_t'(SBOX_DEPTH - 1);

	logic [3:0] state_q;
	cfg_data_t  key_low_q, key_high_q;
	sbox_addr_t n_q, i_q, j_q;
	byte_t      si_q, sj_q, data_q, out_byte_q;
	logic       last_q, out_last_q, out_valid_q, restart_q, fwd_q;

	logic       ram_we, ram_re;
	sbox_addr_t ram_waddr, ram_raddr;
	byte_t      ram_wdata, ram_rdata;

	logic       item_acc, cfg_wr, out_free, out_load;
	sbox_addr_t ksa_j, prga_j, ks_addr;
	byte_t      ks;

	assign pready     = 1'b1;
	assign prdata     = (paddr[3] == REG_KEY_HIGH) ? key_high_q : key_low_q;
	assign cfg_wr     = psel & penable & pwrite;
	assign item_ready = (state_q == ST_IDLE);
	assign item_acc   = item_valid & item_ready;
	assign out_free   = ~out_valid_q | result_ready;
	assign out_load   = (state_q == ST_P_OUT) & out_free;

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_last     = out_last_q;

	assign ksa_j   = j_q + ram_rdata + key_byte(key_low_q, key_high_q,
		key_idx_t'(n_q % KEY_BYTES));
	assign prga_j  = j_q + ram_rdata;
	assign ks_addr = si_q + sj_q;
	// The S[j] write lands in the same cycle as the keystream read: forward it.
	assign ks      = fwd_q ? si_q : ram_rdata;

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(SBOX_DEPTH)
	) u_sbox (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = n_q;
		ram_wdata = n_q;
		ram_re    = 1'b0;
		ram_raddr = n_q;
		case (state_q)
			ST_IDLE: begin
				ram_re    = item_acc & ~restart_q;
				ram_raddr = i_q + 1'b1;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			ST_K_RI: begin
				ram_re = 1'b1;
			end
			ST_K_RJ: begin
				ram_re    = 1'b1;
				ram_raddr = ksa_j;
			end
			ST_K_WI: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_K_WJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
			end
			ST_P_RI: begin
				ram_re    = 1'b1;
				ram_raddr = i_q + 1'b1;
			end
			ST_P_RJ: begin
				ram_re    = 1'b1;
				ram_raddr = prga_j;
			end
			ST_P_WI: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata;
			end
			ST_P_WJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
				ram_re    = 1'b1;
				ram_raddr = ks_addr;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3] == REG_KEY_HIGH) begin
				key_high_q <= pwdata;
			end else begin
				key_low_q <= pwdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			data_q <= data_byte;
			last_q <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			si_q        <= '0;
			sj_q        <= '0;
			fwd_q       <= 1'b0;
			restart_q   <= 1'b1;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (result_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						if (restart_q) begin
							n_q     <= '0;
							state_q <= ST_FILL;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_P_RJ;
						end
					end
				end
				ST_FILL: begin
					n_q <= n_q + 1'b1;
					if (n_q == LAST_ENTRY) begin
						j_q     <= '0;
						state_q <= ST_K_RI;
					end
				end
				ST_K_RI: begin
					state_q <= ST_K_RJ;
				end
				ST_K_RJ: begin
					j_q     <= ksa_j;
					si_q    <= ram_rdata;
					state_q <= ST_K_WI;
				end
				ST_K_WI: begin
					state_q <= ST_K_WJ;
				end
				ST_K_WJ: begin
					n_q <= n_q + 1'b1;
					if (n_q == LAST_ENTRY) begin
						i_q       <= '0;
						j_q       <= '0;
						restart_q <= 1'b0;
						state_q   <= ST_P_RI;
					end else begin
						state_q <= ST_K_RI;
					end
				end
				ST_P_RI: begin
					i_q     <= i_q + 1'b1;
					state_q <= ST_P_RJ;
				end
				ST_P_RJ: begin
					j_q     <= prga_j;
					si_q    <= ram_rdata;
					state_q <= ST_P_WI;
				end
				ST_P_WI: begin
					sj_q    <= ram_rdata;
					state_q <= ST_P_WJ;
				end
				ST_P_WJ: begin
					fwd_q   <= (ks_addr == j_q);
					state_q <= ST_P_OUT;
				end
				ST_P_OUT: begin
					// Hold until the output register is free.
					if (out_free) begin
						out_byte_q  <= data_q ^ ks;
						out_last_q  <= last_q;
						out_valid_q <= 1'b1;
						restart_q   <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
